>>> sv/psk_pkg.sv
// Shared types and constants for the price key sorter.
package psk_pkg;

	localparam int KEY_W = 48;

	typedef logic [KEY_W-1:0] key_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic insert;     // store the input key in order
		logic mark_drop;  // store full: note the lost key
		logic shift;      // head key taken: move the row down
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic full;       // every slot holds a key
		logic one_left;   // only the head slot holds a key
	} dp_sts_t;

endpackage

>>> sv/psk_if.sv
// Valid/ready channel interfaces for input keys and sorted results.
interface psk_in_if;
	logic                valid;
	logic                ready;
	logic [psk_pkg::KEY_W-1:0] price;
	logic                is_last;

	modport source (output valid, output price, output is_last, input ready);
	modport sink   (input valid, input price, input is_last, output ready);
endinterface

interface psk_out_if;
	logic                valid;
	logic                ready;
	logic [psk_pkg::KEY_W-1:0] sorted_price;
	logic                last_out;
	logic                overflow;

	modport source (output valid, output sorted_price, output last_out, output overflow,
		input ready);
	modport sink   (input valid, input sorted_price, input last_out, input overflow,
		output ready);
endinterface

>>> sv/price_key_sorter.sv
// Top level of the price key sorter: controller, sorted slot row and channel wiring.
//
// Usage:
//   key_in  carries price keys (48-bit unsigned) with is_last marking the end of a batch.
//   key_out carries the batch back in ascending order: sorted_price, last_out on the
//   final item, and overflow on every item if any key of the batch was dropped.
//   Up to MAX_KEYS keys are held; further keys of the batch are discarded.
// Timing:
//   Each key is inserted into place in the cycle it is accepted (one compare per slot),
//   so input runs at one item per cycle while loading. After the last key is accepted,
//   the first result is valid the next cycle and results follow at one per cycle while
//   key_out is ready. No new key is taken while a batch drains; every key leaves
//   through the single head slot.
// Reset:
//   arst_n clears the count, the drop flag and the controller; the block starts loading.
// Backpressure:
//   A stalled receiver holds the head item steady on key_out; nothing is lost.
module price_key_sorter #(
	parameter int MAX_KEYS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	psk_in_if.sink     key_in,
	psk_out_if.source  key_out
);
	import psk_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	psk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (key_in.valid),
		.in_last   (key_in.is_last),
		.in_ready  (key_in.ready),
		.out_valid (key_out.valid),
		.out_ready (key_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	psk_datapath #(
		.MAX_KEYS (MAX_KEYS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key      (key_in.price),
		.sts      (sts),
		.head_key (key_out.sorted_price),
		.dropped  (key_out.overflow)
	);

	assign key_out.last_out = sts.one_left;

endmodule

>>> sv/psk_datapath.sv
// Sorted slot row with key count and drop flag: inserts in order, drains from the head.
module psk_datapath #(
	parameter int MAX_KEYS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  psk_pkg::dp_cmd_t  cmd,
	input  psk_pkg::key_t     key,
	output psk_pkg::dp_sts_t  sts,
	output psk_pkg::key_t     head_key,
	output logic              dropped
);
	import psk_pkg::*;

	localparam int CW = $clog2(MAX_KEYS + 1);

	key_t            slot_q [MAX_KEYS];
	logic [CW-1:0]   count_q;
	logic            dropped_q;
	logic [MAX_KEYS-1:0] goes_before;

	// Each slot compares the new key with its own; an empty slot always yields
	generate
		for (genvar i = 0; i < MAX_KEYS; i++) begin : g_slot
			assign goes_before[i] = (CW'(i) >= count_q) || (key < slot_q[i]);

			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (goes_before[i]) begin
						if (i == 0)
							slot_q[i] <= key;
						else if (!goes_before[(i == 0) ? 0 : i-1])
							slot_q[i] <= key;
						else
							slot_q[i] <= slot_q[(i == 0) ? 0 : i-1];
					end
				end else if (cmd.shift) begin
					if (i < MAX_KEYS - 1)
						slot_q[i] <= slot_q[(i < MAX_KEYS - 1) ? i+1 : i];
				end
			end
		end
	endgenerate

	// Key count and drop flag; both clear as the final key leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.insert)
				count_q <= count_q + CW'(1);
			else if (cmd.shift)
				count_q <= count_q - CW'(1);

			if (cmd.mark_drop)
				dropped_q <= 1'b1;
			else if (cmd.shift && sts.one_left)
				dropped_q <= 1'b0;
		end
	end

	assign sts.full     = (count_q == CW'(MAX_KEYS));
	assign sts.one_left = (count_q == CW'(1));
	assign head_key     = slot_q[0];
	assign dropped      = dropped_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEYS))
		else $error("key count beyond capacity");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (slot_q[0] <= slot_q[1]))
		else $error("head slots out of order");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && !cmd.insert) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("drain did not drop the count");

	a_no_store_full: assert property (@(posedge clk) disable iff (!arst_n)
		sts.full |-> !cmd.insert)
		else $error("insert while full");
`endif

endmodule

>>> sv/psk_ctrl.sv
// Load/drain controller for the price key sorter.
module psk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  psk_pkg::dp_sts_t  sts,
	output psk_pkg::dp_cmd_t  cmd
);
	import psk_pkg::*;

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic in_acc;
	logic out_acc;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_DRAIN);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	// Datapath commands
	assign cmd.insert    = in_acc && !sts.full;
	assign cmd.mark_drop = in_acc && sts.full;
	assign cmd.shift     = out_acc;

	// Load until the last key, then drain until the row is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc && in_last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (out_acc && sts.one_left)
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the price key sorter: batch stimulus, sort prediction, result check.
module testbench;
	import psk_pkg::*;

	localparam int MAX_KEYS = 16;
	localparam int CLK_HALF = 10;
	localparam int DRAIN_CYCLES = 4 * MAX_KEYS + 8;

	// One key waiting to be sent; hold keeps it back until the sorter has drained
	typedef struct {
		key_t price;
		logic last;
		bit   hold;
	} key_item_t;

	// One sorted key as it should leave the block
	typedef struct {
		key_t price;
		logic last;
		logic overflow;
	} sorted_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psk_in_if  key_in_ch ();
	psk_out_if key_out_ch ();

	price_key_sorter #(
		.MAX_KEYS(MAX_KEYS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.key_in (key_in_ch),
		.key_out(key_out_ch)
	);

	key_item_t    keys_to_send[$];
	sorted_item_t sorted_due[$];
	int           error_count = 0;

	// Batch store of the predictor
	key_t held_keys[MAX_KEYS];
	int   held_count = 0;
	logic held_dropped = 1'b0;

	// Store one accepted key; on the last key, queue the batch in ascending order
	task automatic store_key_and_sort(input key_t key, input logic last);
		key_t run[MAX_KEYS];
		key_t swap_key;
		sorted_item_t item;
		if (held_count < MAX_KEYS) begin
			held_keys[held_count] = key;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (last) begin
			for (int i = 0; i < held_count; i++)
				run[i] = held_keys[i];
			for (int pass = 0; pass < held_count; pass++) begin
				for (int pos = 0; pos + 1 < held_count; pos++) begin
					if (run[pos] > run[pos + 1]) begin
						swap_key = run[pos];
						run[pos] = run[pos + 1];
						run[pos + 1] = swap_key;
					end
				end
			end
			for (int i = 0; i < held_count; i++) begin
				item.price = run[i];
				item.last = (i + 1 == held_count);
				item.overflow = held_dropped;
				sorted_due.push_back(item);
			end
			held_count = 0;
			held_dropped = 1'b0;
		end
	endtask

	task automatic add_key(input key_t price, input logic last, input bit hold);
		key_item_t item;
		item.price = price;
		item.last = last;
		item.hold = hold;
		keys_to_send.push_back(item);
	endtask

	// Random key, weighted toward the extremes and small values (gives equal keys)
	function automatic key_t rand_key();
		logic [63:0] wide;
		case ($urandom_range(0, 9))
			0: rand_key = '0;
			1: rand_key = '1;
			2: rand_key = key_t'($urandom_range(0, 7));
			3: rand_key = '1 - key_t'($urandom_range(0, 3));
			default: begin
				wide = {$urandom, $urandom};
				rand_key = wide[KEY_W-1:0];
			end
		endcase
	endfunction

	// Clock
	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Run limit
	initial begin
		#(8000000);
		$display("CHECK FAILED");
		$finish;
	end

	// Key driver: bursts and gaps, optional wait for a fully drained sorter
	int        gap_left = 0;
	int        burst_left = 0;
	key_item_t next_key;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_in_ch.valid   <= 1'b0;
			key_in_ch.price   <= '0;
			key_in_ch.is_last <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (key_in_ch.valid && key_in_ch.ready)
				store_key_and_sort(key_in_ch.price, key_in_ch.is_last);
			if (!key_in_ch.valid || key_in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					key_in_ch.valid <= 1'b0;
				end else if (keys_to_send.size() != 0 &&
						(!keys_to_send[0].hold || sorted_due.size() == 0)) begin
					next_key = keys_to_send.pop_front();
					key_in_ch.valid   <= 1'b1;
					key_in_ch.price   <= next_key.price;
					key_in_ch.is_last <= next_key.last;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					key_in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall pattern
	int stall_kind = 0;
	int stall_left = 0;
	int phase = 0;
	sorted_item_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_out_ch.ready <= 1'b0;
			stall_kind = 0;
			stall_left = 0;
			phase = 0;
		end else begin
			if (key_out_ch.valid && key_out_ch.ready) begin
				if (sorted_due.size() == 0) begin
					$display("%0t: unexpected item: price %h last %b overflow %b", $time,
						key_out_ch.sorted_price, key_out_ch.last_out, key_out_ch.overflow);
					error_count++;
				end else begin
					want = sorted_due.pop_front();
					if (key_out_ch.sorted_price !== want.price) begin
						$display("%0t: sorted_price expected %h actual %h", $time,
							want.price, key_out_ch.sorted_price);
						error_count++;
					end
					if (key_out_ch.last_out !== want.last) begin
						$display("%0t: last_out expected %b actual %b", $time,
							want.last, key_out_ch.last_out);
						error_count++;
					end
					if (key_out_ch.overflow !== want.overflow) begin
						$display("%0t: overflow expected %b actual %b", $time,
							want.overflow, key_out_ch.overflow);
						error_count++;
					end
				end
			end
			// stretches of always ready, coin flips, long stalls and a fixed rhythm
			if (stall_left == 0) begin
				stall_kind = $urandom_range(0, 3);
				stall_left = $urandom_range(4, 40);
			end else begin
				stall_left--;
			end
			phase++;
			case (stall_kind)
				0: key_out_ch.ready <= 1'b1;
				1: key_out_ch.ready <= ($urandom_range(0, 1) == 1);
				2: key_out_ch.ready <= ($urandom_range(0, 7) == 0);
				default: key_out_ch.ready <= (phase % 4 != 3);
			endcase
		end
	end

	// Stimulus, reset and end of run
	int sent;
	int batch_size;
	int batch_no;

	initial begin
		// single-key batches at both extremes
		add_key('0, 1'b1, 1'b0);
		add_key('1, 1'b1, 1'b0);
		// full store in descending order, then a last key that finds it full
		for (int i = 0; i < MAX_KEYS; i++)
			add_key((i == 0) ? key_t'('1) : key_t'(MAX_KEYS - i), 1'b0, 1'b0);
		add_key(key_t'(1), 1'b1, 1'b0);
		// equal keys, sent after the sorter has drained
		add_key(key_t'(5), 1'b0, 1'b1);
		add_key(key_t'(5), 1'b0, 1'b0);
		add_key('0, 1'b1, 1'b0);

		// random batches, mostly within capacity, some overflowing
		sent = 0;
		batch_no = 0;
		while (sent < 300) begin
			batch_size = ($urandom_range(0, 6) == 0) ? $urandom_range(MAX_KEYS + 1, MAX_KEYS + 8)
				: $urandom_range(1, MAX_KEYS);
			for (int i = 0; i < batch_size; i++)
				add_key(rand_key(), i + 1 == batch_size,
					i == 0 && (batch_no == 2 || $urandom_range(0, 7) == 0));
			sent += batch_size;
			batch_no++;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (keys_to_send.size() != 0 || key_in_ch.valid || sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
